FILE: rtl/core/mvlt_pkg.sv
package mvlt_pkg;

   localparam int TIMER_BITS = 24;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int TIMEOUT_BITS = 24;

   typedef enum logic [1:0] {
      KIND_TICK    = 2'd0,
      KIND_COMMAND = 2'd1,
      KIND_SWITCH  = 2'd2,
      KIND_INIT    = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      REG_IN_INVERT     = 3'd0,
      REG_OUT_INVERT    = 3'd1,
      REG_NO_FEEDBACK   = 3'd2,
      REG_TIMEOUT_TICKS = 3'd3,
      REG_BOOT_MODE     = 3'd4
   } reg_index_type;

   localparam logic [1:0] POS_OPEN = 2'd1;
   localparam logic [1:0] POS_SHUT = 2'd2;

   localparam logic [1:0] BOOT_OPEN = 2'd1;
   localparam logic [1:0] BOOT_SHUT = 2'd2;

   localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = TIMEOUT_BITS'(30000);

endpackage

FILE: rtl/core/motor_valve_limit_timeout_ctrl.sv
// Motorized two-position valve controller. Each req transaction is one event (tick, open/shut
// command, limit switch change or initialize) and produces exactly one rsp transaction that
// reports the pin levels, measured and target position, the moving flag and whether this event
// ended a motion. Events are taken one per clock cycle while req_tready is high; the output
// register is loaded in the cycle after acceptance; req_tready is low only while it holds a
// result the sink has not taken. The whole event update is one pass of logic between the state
// registers and the output register. Configuration registers sit on the csr APB port at byte
// addresses 0x00 in_invert, 0x04 out_invert, 0x08 no_feedback, 0x0c timeout_ticks,
// 0x10 boot_mode, and are to be written only while no event is in flight.
module motor_valve_limit_timeout_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [0] command_open, [1] switch_sel, [2] switch_level, [3] open_level, [4] shut_level
   input  logic [7:0]                          req_tdata,
   // [1:0] kind
   input  logic [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] power_pin, [1] open_pin, [3:2] position, [5:4] target, [6] moving, [7] status_report
   output logic [7:0]                          rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mvlt_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [mvlt_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [mvlt_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import mvlt_pkg::*;

   logic                     in_invert_ff, out_invert_ff, no_feedback_ff;
   logic [TIMEOUT_BITS-1:0]  timeout_ff;
   logic [1:0]               boot_mode_ff;

   logic [1:0]               pos_ff, pos_in;
   logic [1:0]               tgt_ff, tgt_in;
   logic                     run_ff, run_in;
   logic [TIMER_BITS-1:0]    rem_ff, rem_in;
   logic                     power_ff, power_in;
   logic                     dir_ff, dir_in;
   logic                     report;

   logic                     rsp_valid_ff;
   logic [7:0]               rsp_data_ff;

   logic                     req_fire, csr_write;
   reg_index_type            csr_index;
   kind_type                 kind;
   logic                     cmd_open, sw_sel, sw_level, open_lv, shut_lv;
   logic [1:0]               sw_bit, sampled;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_BITS-1:2]);

   always_comb begin
      csr_prdata = '0;
      case (csr_index)
         REG_IN_INVERT:     csr_prdata[0] = in_invert_ff;
         REG_OUT_INVERT:    csr_prdata[0] = out_invert_ff;
         REG_NO_FEEDBACK:   csr_prdata[0] = no_feedback_ff;
         REG_TIMEOUT_TICKS: csr_prdata[TIMEOUT_BITS-1:0] = timeout_ff;
         REG_BOOT_MODE:     csr_prdata[1:0] = boot_mode_ff;
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_invert_ff   <= 1'b0;
         out_invert_ff  <= 1'b0;
         no_feedback_ff <= 1'b0;
         timeout_ff     <= TIMEOUT_RESET;
         boot_mode_ff   <= 2'd0;
      end else if (csr_write) begin
         case (csr_index)
            REG_IN_INVERT:     in_invert_ff   <= csr_pwdata[0];
            REG_OUT_INVERT:    out_invert_ff  <= csr_pwdata[0];
            REG_NO_FEEDBACK:   no_feedback_ff <= csr_pwdata[0];
            REG_TIMEOUT_TICKS: timeout_ff     <= csr_pwdata[TIMEOUT_BITS-1:0];
            REG_BOOT_MODE:     boot_mode_ff   <= csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_fire   = req_tvalid & req_tready;

   assign kind     = kind_type'(req_tuser);
   assign cmd_open = req_tdata[0];
   assign sw_sel   = req_tdata[1];
   assign sw_level = req_tdata[2];
   assign open_lv  = req_tdata[3];
   assign shut_lv  = req_tdata[4];
   assign sw_bit   = sw_sel ? POS_SHUT : POS_OPEN;
   assign sampled  = {shut_lv ^ in_invert_ff, open_lv ^ in_invert_ff};

   always_comb begin
      pos_in   = pos_ff;
      tgt_in   = tgt_ff;
      run_in   = run_ff;
      rem_in   = rem_ff;
      power_in = power_ff;
      dir_in   = dir_ff;
      report   = 1'b0;
      case (kind)
         KIND_TICK: begin
            if (run_ff) begin
               if (rem_ff <= TIMER_BITS'(1)) begin
                  report = 1'b1;
               end else begin
                  rem_in = rem_ff - TIMER_BITS'(1);
               end
            end
         end
         KIND_COMMAND: begin
            tgt_in = cmd_open ? POS_OPEN : POS_SHUT;
         end
         KIND_SWITCH: begin
            if (!no_feedback_ff) begin
               if (sw_level ^ in_invert_ff) pos_in = pos_ff | sw_bit;
               else                         pos_in = pos_ff & ~sw_bit;
               report = run_ff && (pos_in == tgt_ff);
            end
         end
         KIND_INIT: begin
            if (!no_feedback_ff) begin
               pos_in = sampled;
               tgt_in = sampled;
            end
            if (boot_mode_ff == BOOT_OPEN) tgt_in = POS_OPEN;
            else if (boot_mode_ff == BOOT_SHUT) tgt_in = POS_SHUT;
         end
         default: ;
      endcase

      // start of a motion: command, or initialize with a boot command
      if (kind == KIND_COMMAND ||
          (kind == KIND_INIT && (boot_mode_ff == BOOT_OPEN || boot_mode_ff == BOOT_SHUT))) begin
         rem_in   = TIMER_BITS'(timeout_ff);
         run_in   = 1'b1;
         power_in = 1'b1;
         dir_in   = (tgt_in == POS_OPEN);
      end

      if (report) begin
         run_in   = 1'b0;
         rem_in   = '0;
         power_in = 1'b0;
         dir_in   = 1'b0;
         if (no_feedback_ff) pos_in = tgt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 2'd0;
         tgt_ff       <= 2'd0;
         run_ff       <= 1'b0;
         rem_ff       <= '0;
         power_ff     <= 1'b0;
         dir_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            pos_ff   <= pos_in;
            tgt_ff   <= tgt_in;
            run_ff   <= run_in;
            rem_ff   <= rem_in;
            power_ff <= power_in;
            dir_ff   <= dir_in;
         end
         if (req_fire)       rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= {report, run_in, tgt_in, pos_in,
                         dir_in ^ out_invert_ff, power_in ^ out_invert_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: rtl/core/mvlt_checker.sv
module mvlt_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [7:0]                          req_tdata,
   input  logic [1:0]                          req_tuser,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [7:0]                          rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mvlt_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [mvlt_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   input  logic [mvlt_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   input  logic                                csr_pready
);
   import mvlt_pkg::*;

   // every accepted transaction yields a result in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("no result after accepted transaction");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // the item that ends a motion leaves the valve stopped
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[7] |-> !rsp_tdata[6])
      else $error("status report while still moving");

   // when stopped both pins sit at the same inactive level
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[6] |-> rsp_tdata[0] == rsp_tdata[1])
      else $error("pins driven while stopped");

   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind motor_valve_limit_timeout_ctrl mvlt_checker u_mvlt_checker (.*);
